[rtl/core/rrts_pkg.sv]
`timescale 1ns / 1ps
package rrts_pkg;

    localparam int DEF_NUM_TASKS = 16;
    localparam int DEF_NUM_CPUS  = 4;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_SET_CUR = 2'd1,
        CMD_SWITCH  = 2'd2,
        CMD_KILL    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_BLOCKED = 2'd3
    } t_slot_st;

    localparam logic [1:0] KIND_BLOCK = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_NO_SWITCH = 3'd1;
    localparam logic [2:0] STS_NOT_FOUND = 3'd2;
    localparam logic [2:0] STS_RUNNING   = 3'd3;
    localparam logic [2:0] STS_FULL      = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_CR_LINK,
        S_CR_HEAD,
        S_SC_DONE,
        S_SW_TICK,
        S_SW_FIRST,
        S_SW_WALK,
        S_KL_WALK,
        S_KL_PRED,
        S_RESP
    } t_fsm;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] ctx;
        logic [15:0] pid;
        logic [3:0]  slot;
    } t_res;

    function automatic t_res mk_res(logic [2:0] sts, logic [31:0] ctx,
                                    logic [15:0] pid, logic [3:0] slot);
        t_res r;
        r.status = sts;
        r.ctx    = ctx;
        r.pid    = pid;
        r.slot   = slot;
        return r;
    endfunction

endpackage

[rtl/core/round_robin_task_scheduler.sv]
`timescale 1ns / 1ps
// Round-robin task scheduler for several processors.
// Input channel (i_valid/o_ready) takes one command per transaction: create,
// set_current, switch or kill. Output channel (o_valid/i_ready) returns one
// result per command: status, context, pid and slot.
// One command is handled at a time. Switch walks the ring links from the
// current task; kill walks from the head to the victim and, to unlink it,
// on to its predecessor.
// The ring walk reads one link per cycle from the link/pid memory, whose
// read data arrives in the cycle after the address.
// The next command is taken the cycle after the result is loaded into the
// output register, so one result may wait while the next command runs.
// If the receiver stalls, the result holds in the output register and the
// following command finishes but waits until that register frees.
// Reset (synchronous, active low) frees all slots, empties the ring, clears
// all processor bindings and sets the next pid to 1. No clearing pass.
module round_robin_task_scheduler #(
    parameter int NUM_TASKS = rrts_pkg::DEF_NUM_TASKS,
    parameter int NUM_CPUS  = rrts_pkg::DEF_NUM_CPUS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [1:0]  i_cpu,
    input  logic [31:0] i_context_word,
    input  logic [31:0] i_wake_time,
    input  logic [1:0]  i_switch_kind,
    input  logic        i_resched_flag,
    input  logic [15:0] i_target_pid,
    input  logic [3:0]  i_target_slot,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_context_out,
    output logic [15:0] o_pid_out,
    output logic [3:0]  o_slot_out
);
    import rrts_pkg::*;

    localparam int LW = $clog2(NUM_TASKS);

    t_res          res;
    logic [LW-1:0] raddr;
    logic          a_we;
    logic [LW-1:0] a_waddr;
    logic [63:0]   a_wdata;
    logic [63:0]   a_rdata;
    logic          b_we;
    logic [LW-1:0] b_waddr;
    logic [LW+15:0] b_wdata;
    logic [LW+15:0] b_rdata;

    rrts_ctrl #(.NUM_TASKS(NUM_TASKS), .NUM_CPUS(NUM_CPUS), .LW(LW)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_command, .i_cpu, .i_context_word, .i_wake_time, .i_switch_kind,
        .i_resched_flag, .i_target_pid, .i_target_slot,
        .o_valid, .i_ready,
        .o_res     (res),
        .o_raddr   (raddr),
        .o_a_we    (a_we),
        .o_a_waddr (a_waddr),
        .o_a_wdata (a_wdata),
        .i_a_rdata (a_rdata),
        .o_b_we    (b_we),
        .o_b_waddr (b_waddr),
        .o_b_wdata (b_wdata),
        .i_b_rdata (b_rdata)
    );

    // context and wake tick
    rrts_ram #(.WIDTH(64), .DEPTH(NUM_TASKS)) u_ctx_ram (
        .i_clk, .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(raddr), .o_rdata(a_rdata)
    );

    // ring link and pid
    rrts_ram #(.WIDTH(LW + 16), .DEPTH(NUM_TASKS)) u_link_ram (
        .i_clk, .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(raddr), .o_rdata(b_rdata)
    );

    assign o_status      = res.status;
    assign o_context_out = res.ctx;
    assign o_pid_out     = res.pid;
    assign o_slot_out    = res.slot;
endmodule

[rtl/core/rrts_ram.sv]
`timescale 1ns / 1ps
module rrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = rrts_pkg::DEF_NUM_TASKS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/rrts_ctrl.sv]
`timescale 1ns / 1ps
module rrts_ctrl #(
    parameter int NUM_TASKS = rrts_pkg::DEF_NUM_TASKS,
    parameter int NUM_CPUS  = rrts_pkg::DEF_NUM_CPUS,
    parameter int LW        = $clog2(NUM_TASKS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_command,
    input  logic [1:0]       i_cpu,
    input  logic [31:0]      i_context_word,
    input  logic [31:0]      i_wake_time,
    input  logic [1:0]       i_switch_kind,
    input  logic             i_resched_flag,
    input  logic [15:0]      i_target_pid,
    input  logic [3:0]       i_target_slot,
    output logic             o_valid,
    input  logic             i_ready,
    output rrts_pkg::t_res   o_res,
    output logic [LW-1:0]    o_raddr,
    output logic             o_a_we,
    output logic [LW-1:0]    o_a_waddr,
    output logic [63:0]      o_a_wdata,
    input  logic [63:0]      i_a_rdata,
    output logic             o_b_we,
    output logic [LW-1:0]    o_b_waddr,
    output logic [LW+15:0]   o_b_wdata,
    input  logic [LW+15:0]   i_b_rdata
);
    import rrts_pkg::*;

    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    t_fsm        r_fsm, n_fsm;
    t_slot_st    r_state [NUM_TASKS];
    logic [LW-1:0] r_head;
    logic        r_head_vld;
    logic [LW-1:0] r_cur [NUM_CPUS];
    logic [NUM_CPUS-1:0] r_cur_vld;
    logic [15:0] r_pid_ctr;

    t_cmd        r_cmd;
    logic [1:0]  r_cpu;
    logic [31:0] r_ctx;
    logic [31:0] r_wake;
    logic [1:0]  r_kind;
    logic        r_resched;
    logic [15:0] r_tpid;
    logic [3:0]  r_tslot;

    logic [LW-1:0] r_t;
    logic [LW-1:0] r_p;
    logic [LW-1:0] r_cs;
    logic [LW-1:0] r_new;
    logic [LW-1:0] r_lnk;
    logic [15:0] r_save_pid;
    logic [15:0] r_cur_pid;
    t_res        r_res;
    t_res        r_out;
    logic        r_o_valid;

    logic [CW-1:0] cpu_idx;
    logic        cpu_ok;
    logic        slot_ok;
    logic [LW-1:0] sidx;
    logic [LW-1:0] cur_slot;
    logic        has_cur;
    logic        is_block;
    logic        tick_skip;
    logic [31:0] a_ctx;
    logic [LW-1:0] b_link;
    logic [15:0] b_pid;
    logic        sw_hit;
    logic        kl_hit;
    logic        free_any;
    logic [LW-1:0] free_idx;
    logic        out_load;

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_TASKS - 1; i >= 0; i--) begin
            if (r_state[i] == ST_FREE) begin
                free_any = 1'b1;
                free_idx = LW'(i);
            end
        end
    end

    assign cpu_idx   = CW'(r_cpu);
    assign cpu_ok    = 32'(r_cpu) < NUM_CPUS;
    assign sidx      = LW'(r_tslot);
    assign slot_ok   = (32'(r_tslot) < NUM_TASKS) && (r_state[sidx] != ST_FREE);
    assign cur_slot  = r_cur[cpu_idx];
    assign has_cur   = cpu_ok && r_cur_vld[cpu_idx];
    assign is_block  = r_kind == KIND_BLOCK;
    assign tick_skip = (r_kind == KIND_TICK) && !r_resched;
    assign a_ctx     = i_a_rdata[63:32];
    assign b_link    = i_b_rdata[LW+15:16];
    assign b_pid     = i_b_rdata[15:0];
    assign sw_hit    = (r_state[r_t] == ST_READY) && (a_ctx != 32'd0);
    assign kl_hit    = b_pid == r_tpid;
    assign out_load  = !r_o_valid || i_ready;

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE: begin
                if (i_valid) n_fsm = S_DEC;
            end
            S_DEC: begin
                unique case (r_cmd)
                    CMD_CREATE:  n_fsm = (free_any && r_head_vld) ? S_CR_LINK : S_RESP;
                    CMD_SET_CUR: n_fsm = (cpu_ok && slot_ok) ? S_SC_DONE : S_RESP;
                    CMD_SWITCH: begin
                        if (!has_cur) n_fsm = S_RESP;
                        else if (tick_skip) n_fsm = S_SW_TICK;
                        else n_fsm = S_SW_FIRST;
                    end
                    CMD_KILL:    n_fsm = r_head_vld ? S_KL_WALK : S_RESP;
                    default:     n_fsm = S_RESP;
                endcase
            end
            S_CR_LINK:  n_fsm = S_CR_HEAD;
            S_CR_HEAD:  n_fsm = S_RESP;
            S_SC_DONE:  n_fsm = S_RESP;
            S_SW_TICK:  n_fsm = S_RESP;
            S_SW_FIRST: n_fsm = (b_link == r_cs) ? S_RESP : S_SW_WALK;
            S_SW_WALK: begin
                if (sw_hit || b_link == r_cs) n_fsm = S_RESP;
            end
            S_KL_WALK: begin
                if (kl_hit) begin
                    if (r_state[r_t] == ST_RUNNING || b_link == r_t) n_fsm = S_RESP;
                    else n_fsm = S_KL_PRED;
                end else if (b_link == r_head) begin
                    n_fsm = S_RESP;
                end
            end
            S_KL_PRED: begin
                if (b_link == r_t) n_fsm = S_RESP;
            end
            S_RESP: begin
                if (out_load) n_fsm = S_IDLE;
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    always_comb begin
        o_raddr   = '0;
        o_a_we    = 1'b0;
        o_a_waddr = '0;
        o_a_wdata = '0;
        o_b_we    = 1'b0;
        o_b_waddr = '0;
        o_b_wdata = '0;
        unique case (r_fsm)
            S_DEC: begin
                unique case (r_cmd)
                    CMD_CREATE: begin
                        o_raddr = r_head;
                        if (free_any && !r_head_vld) begin
                            o_a_we    = 1'b1;
                            o_a_waddr = free_idx;
                            o_a_wdata = {r_ctx, 32'd0};
                            o_b_we    = 1'b1;
                            o_b_waddr = free_idx;
                            o_b_wdata = {free_idx, r_pid_ctr};
                        end
                    end
                    CMD_SET_CUR: o_raddr = sidx;
                    CMD_SWITCH: begin
                        o_raddr = cur_slot;
                        if (has_cur && !tick_skip) begin
                            o_a_we    = 1'b1;
                            o_a_waddr = cur_slot;
                            o_a_wdata = {r_ctx, is_block ? r_wake : 32'd0};
                        end
                    end
                    CMD_KILL:    o_raddr = r_head;
                    default:     o_raddr = '0;
                endcase
            end
            S_CR_LINK: begin
                o_a_we    = 1'b1;
                o_a_waddr = r_new;
                o_a_wdata = {r_ctx, 32'd0};
                o_b_we    = 1'b1;
                o_b_waddr = r_new;
                o_b_wdata = {b_link, r_pid_ctr};
            end
            S_CR_HEAD: begin
                o_b_we    = 1'b1;
                o_b_waddr = r_head;
                o_b_wdata = {r_new, r_save_pid};
            end
            S_SW_FIRST, S_SW_WALK, S_KL_WALK: o_raddr = b_link;
            S_KL_PRED: begin
                if (b_link == r_t) begin
                    o_b_we    = 1'b1;
                    o_b_waddr = r_p;
                    o_b_wdata = {r_lnk, b_pid};
                end else begin
                    o_raddr = b_link;
                end
            end
            default: o_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm      <= S_IDLE;
            r_head_vld <= 1'b0;
            r_cur_vld  <= '0;
            r_pid_ctr  <= 16'd1;
            r_o_valid  <= 1'b0;
            for (int i = 0; i < NUM_TASKS; i++) r_state[i] <= ST_FREE;
        end else begin
            r_fsm <= n_fsm;
            if (r_fsm == S_RESP && out_load) r_o_valid <= 1'b1;
            else if (i_ready) r_o_valid <= 1'b0;
            unique case (r_fsm)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd     <= t_cmd'(i_command);
                        r_cpu     <= i_cpu;
                        r_ctx     <= i_context_word;
                        r_wake    <= i_wake_time;
                        r_kind    <= i_switch_kind;
                        r_resched <= i_resched_flag;
                        r_tpid    <= i_target_pid;
                        r_tslot   <= i_target_slot;
                    end
                end
                S_DEC: begin
                    unique case (r_cmd)
                        CMD_CREATE: begin
                            r_new <= free_idx;
                            if (!free_any) begin
                                r_res <= mk_res(STS_FULL, 32'd0, 16'd0, 4'd0);
                            end else if (!r_head_vld) begin
                                r_state[free_idx] <= ST_READY;
                                r_head     <= free_idx;
                                r_head_vld <= 1'b1;
                                r_res      <= mk_res(STS_OK, 32'd0, r_pid_ctr, 4'(free_idx));
                                r_pid_ctr  <= r_pid_ctr + 16'd1;
                            end
                        end
                        CMD_SET_CUR: begin
                            if (!(cpu_ok && slot_ok))
                                r_res <= mk_res(STS_NOT_FOUND, 32'd0, 16'd0, 4'd0);
                        end
                        CMD_SWITCH: begin
                            r_cs <= cur_slot;
                            if (!has_cur)
                                r_res <= mk_res(STS_NO_SWITCH, 32'd0, 16'd0, 4'd0);
                        end
                        CMD_KILL: begin
                            r_t <= r_head;
                            if (!r_head_vld)
                                r_res <= mk_res(STS_NOT_FOUND, 32'd0, 16'd0, 4'd0);
                        end
                        default: r_t <= r_head;
                    endcase
                end
                S_CR_LINK: begin
                    r_state[r_new] <= ST_READY;
                    r_save_pid     <= b_pid;
                    r_res          <= mk_res(STS_OK, 32'd0, r_pid_ctr, 4'(r_new));
                    r_pid_ctr      <= r_pid_ctr + 16'd1;
                end
                S_SC_DONE: begin
                    for (int c = 0; c < NUM_CPUS; c++) begin
                        if (CW'(c) != cpu_idx && r_cur_vld[c] && r_cur[c] == sidx)
                            r_cur_vld[c] <= 1'b0;
                    end
                    if (r_cur_vld[cpu_idx] && r_cur[cpu_idx] != sidx)
                        r_state[r_cur[cpu_idx]] <= ST_READY;
                    r_state[sidx]      <= ST_RUNNING;
                    r_cur[cpu_idx]     <= sidx;
                    r_cur_vld[cpu_idx] <= 1'b1;
                    r_res <= mk_res(STS_OK, 32'd0, b_pid, 4'(sidx));
                end
                S_SW_TICK: begin
                    r_res <= mk_res(STS_NO_SWITCH, 32'd0, b_pid, 4'(r_cs));
                end
                S_SW_FIRST: begin
                    r_cur_pid <= b_pid;
                    r_t       <= b_link;
                    if (b_link == r_cs)
                        r_res <= mk_res(STS_NO_SWITCH, 32'd0, b_pid, 4'(r_cs));
                end
                S_SW_WALK: begin
                    if (sw_hit) begin
                        r_state[r_cs]  <= is_block ? ST_BLOCKED : ST_READY;
                        r_state[r_t]   <= ST_RUNNING;
                        r_cur[cpu_idx] <= r_t;
                        r_res <= mk_res(STS_OK, a_ctx, b_pid, 4'(r_t));
                    end else begin
                        r_t <= b_link;
                        if (b_link == r_cs)
                            r_res <= mk_res(STS_NO_SWITCH, 32'd0, r_cur_pid, 4'(r_cs));
                    end
                end
                S_KL_WALK: begin
                    if (kl_hit) begin
                        if (r_state[r_t] == ST_RUNNING) begin
                            r_res <= mk_res(STS_RUNNING, 32'd0, r_tpid, 4'(r_t));
                        end else if (b_link == r_t) begin
                            r_head_vld   <= 1'b0;
                            r_state[r_t] <= ST_FREE;
                            r_res <= mk_res(STS_OK, 32'd0, r_tpid, 4'(r_t));
                        end else begin
                            r_lnk <= b_link;
                            r_p   <= b_link;
                        end
                    end else begin
                        r_t <= b_link;
                        if (b_link == r_head)
                            r_res <= mk_res(STS_NOT_FOUND, 32'd0, 16'd0, 4'd0);
                    end
                end
                S_KL_PRED: begin
                    if (b_link == r_t) begin
                        if (r_head == r_t) r_head <= r_lnk;
                        r_state[r_t] <= ST_FREE;
                        r_res <= mk_res(STS_OK, 32'd0, r_tpid, 4'(r_t));
                    end else begin
                        r_p <= b_link;
                    end
                end
                S_RESP: begin
                    if (out_load) begin
                        r_out <= r_res;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_ready = r_fsm == S_IDLE;
    assign o_valid = r_o_valid;
    assign o_res   = r_out;
endmodule

[rtl/core/rrts_checker.sv]
`timescale 1ns / 1ps
module rrts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [31:0] o_context_out,
    input logic [15:0] o_pid_out,
    input logic [3:0]  o_slot_out
);
    import rrts_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_context_out)
            && $stable(o_pid_out) && $stable(o_slot_out))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second transaction taken while busy");

    a_sts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= STS_FULL)
        else $error("status out of range");

    a_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STS_OK |-> o_context_out == 32'd0)
        else $error("context on failed transaction");

    a_nf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STS_NOT_FOUND || o_status == STS_FULL)
            |-> o_pid_out == 16'd0 && o_slot_out == 4'd0)
        else $error("pid or slot on empty result");
endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
    import rrts_pkg::*;

    localparam int  NT       = DEF_NUM_TASKS;
    localparam int  NC       = DEF_NUM_CPUS;
    localparam int  NO_TASK  = -1;
    localparam byte NO_OWNER = 8'hFF;
    localparam int  LIMIT    = 6000000;

    class sched_scoreboard;
        t_slot_st    st[NT];
        byte         owner[NT];
        logic [31:0] ctx[NT];
        logic [31:0] wake[NT];
        int          link[NT];
        logic [15:0] pid[NT];
        int          head;
        bit          head_ok;
        int          cur[NC];
        logic [15:0] pid_seq;
        t_res        expected_results[$];
        int          errors;
        int          checked;

        function new();
            foreach (st[i]) begin
                st[i] = ST_FREE;
                owner[i] = NO_OWNER;
                ctx[i] = '0;
                wake[i] = '0;
                link[i] = 0;
                pid[i] = '0;
            end
            foreach (cur[c]) cur[c] = NO_TASK;
            head = 0;
            head_ok = 0;
            pid_seq = 16'd1;
            errors = 0;
            checked = 0;
        endfunction

        function t_res res(logic [2:0] s, logic [31:0] c, logic [15:0] p, int sl);
            t_res r;
            r.status = s;
            r.ctx = c;
            r.pid = p;
            r.slot = sl[3:0];
            return r;
        endfunction

        function t_res do_create(logic [31:0] c);
            int s;
            s = NO_TASK;
            for (int i = NT - 1; i >= 0; i--)
                if (st[i] == ST_FREE) s = i;
            if (s == NO_TASK) return res(STS_FULL, 0, 0, 0);
            pid[s] = pid_seq;
            pid_seq = pid_seq + 16'd1;
            owner[s] = NO_OWNER;
            ctx[s] = c;
            wake[s] = '0;
            st[s] = ST_READY;
            if (!head_ok) begin
                head = s;
                head_ok = 1;
                link[s] = s;
            end else begin
                link[s] = link[head];
                link[head] = s;
            end
            return res(STS_OK, 0, pid[s], s);
        endfunction

        function t_res do_set_cur(int cpu, int s);
            int prev;
            if (st[s] == ST_FREE) return res(STS_NOT_FOUND, 0, 0, 0);
            for (int c = 0; c < NC; c++)
                if (c != cpu && cur[c] == s) cur[c] = NO_TASK;
            prev = cur[cpu];
            if (prev != NO_TASK && prev != s && st[prev] == ST_RUNNING
                    && owner[prev] == cpu) begin
                st[prev] = ST_READY;
                owner[prev] = NO_OWNER;
            end
            st[s] = ST_RUNNING;
            owner[s] = byte'(cpu);
            cur[cpu] = s;
            return res(STS_OK, 0, pid[s], s);
        endfunction

        function t_res do_switch(int cpu, logic [1:0] kind, bit rs,
                                 logic [31:0] c, logic [31:0] w);
            int cs;
            int t;
            int found;
            bit blk;
            cs = cur[cpu];
            if (cs == NO_TASK) return res(STS_NO_SWITCH, 0, 0, 0);
            if (kind == KIND_TICK && !rs) return res(STS_NO_SWITCH, 0, pid[cs], cs);
            blk = (kind == KIND_BLOCK);
            ctx[cs] = c;
            wake[cs] = blk ? w : 32'd0;
            st[cs] = blk ? ST_BLOCKED : ST_READY;
            owner[cs] = NO_OWNER;
            found = NO_TASK;
            if (head_ok) begin
                t = link[cs];
                for (int n = 0; n < NT && t != cs; n++) begin
                    if (st[t] == ST_READY && owner[t] == NO_OWNER && ctx[t] != 0) begin
                        found = t;
                        break;
                    end
                    t = link[t];
                end
            end
            if (found == NO_TASK) begin
                st[cs] = ST_RUNNING;
                owner[cs] = byte'(cpu);
                return res(STS_NO_SWITCH, 0, pid[cs], cs);
            end
            st[found] = ST_RUNNING;
            owner[found] = byte'(cpu);
            cur[cpu] = found;
            return res(STS_OK, ctx[found], pid[found], found);
        endfunction

        function t_res do_kill(logic [15:0] p);
            int t;
            int pr;
            if (!head_ok) return res(STS_NOT_FOUND, 0, 0, 0);
            t = head;
            for (int n = 0; n < NT; n++) begin
                if (pid[t] == p) begin
                    if (st[t] == ST_RUNNING) return res(STS_RUNNING, 0, p, t);
                    if (link[t] == t) begin
                        head_ok = 0;
                    end else begin
                        pr = t;
                        for (int k = 0; k < NT && link[pr] != t; k++) pr = link[pr];
                        link[pr] = link[t];
                        if (head == t) head = link[t];
                    end
                    st[t] = ST_FREE;
                    owner[t] = NO_OWNER;
                    return res(STS_OK, 0, p, t);
                end
                t = link[t];
                if (t == head) break;
            end
            return res(STS_NOT_FOUND, 0, 0, 0);
        endfunction

        function void note_command(t_cmd cmd, logic [1:0] cpu, logic [31:0] c,
                                   logic [31:0] w, logic [1:0] kind, bit rs,
                                   logic [15:0] p, logic [3:0] sl);
            t_res r;
            case (cmd)
                CMD_CREATE:  r = do_create(c);
                CMD_SET_CUR: r = do_set_cur(int'(cpu), int'(sl));
                CMD_SWITCH:  r = do_switch(int'(cpu), kind, rs, c, w);
                default:     r = do_kill(p);
            endcase
            expected_results.push_back(r);
        endfunction

        function void check_result(t_res got);
            t_res e;
            checked++;
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status);
                errors++;
            end
            if (got.ctx !== e.ctx) begin
                $error("context_out exp %h got %h", e.ctx, got.ctx);
                errors++;
            end
            if (got.pid !== e.pid) begin
                $error("pid_out exp %0d got %0d", e.pid, got.pid);
                errors++;
            end
            if (got.slot !== e.slot) begin
                $error("slot_out exp %0d got %0d", e.slot, got.slot);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_command;
    logic [1:0]  i_cpu;
    logic [31:0] i_context_word;
    logic [31:0] i_wake_time;
    logic [1:0]  i_switch_kind;
    logic        i_resched_flag;
    logic [15:0] i_target_pid;
    logic [3:0]  i_target_slot;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [31:0] o_context_out;
    logic [15:0] o_pid_out;
    logic [3:0]  o_slot_out;

    sched_scoreboard sb;
    int  cycles = 0;
    int  idle_pct;
    int  sent;
    int  n_switch;

    round_robin_task_scheduler dut (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_ready <= ($urandom_range(99) >= idle_pct);

    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && o_valid && i_ready) begin
            got.status = o_status;
            got.ctx = o_context_out;
            got.pid = o_pid_out;
            got.slot = o_slot_out;
            sb.check_result(got);
        end
    end

    task automatic send(t_cmd cmd, logic [1:0] cpu, logic [31:0] c, logic [31:0] w,
                        logic [1:0] kind, bit rs, logic [15:0] p, logic [3:0] sl);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 0;
            @(negedge i_clk);
        end
        i_valid = 1;
        i_command = cmd;
        i_cpu = cpu;
        i_context_word = c;
        i_wake_time = w;
        i_switch_kind = kind;
        i_resched_flag = rs;
        i_target_pid = p;
        i_target_slot = sl;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        sb.note_command(cmd, cpu, c, w, kind, rs, p, sl);
        sent++;
        if (cmd == CMD_SWITCH) n_switch++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 0;
        while (sb.expected_results.size() != 0) @(negedge i_clk);
        repeat (2 * NT + 10) @(negedge i_clk);
    endtask

    function automatic logic [15:0] live_pid();
        int s;
        s = $urandom_range(NT - 1);
        if (sb.st[s] == ST_FREE || $urandom_range(9) == 0) return 16'($urandom);
        return sb.pid[s];
    endfunction

    task automatic rand_item();
        int r;
        logic [31:0] c;
        logic [31:0] w;
        logic [1:0]  cpu;
        logic [1:0]  kind;
        bit          rs;
        logic [15:0] p;
        logic [3:0]  sl;
        r = $urandom_range(99);
        c = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
        w = $urandom;
        cpu = 2'($urandom);
        kind = 2'($urandom);
        rs = 1'($urandom);
        p = 16'($urandom);
        sl = 4'($urandom);
        if (r < 22)
            send(CMD_CREATE, cpu, c, w, kind, rs, p, sl);
        else if (r < 40)
            send(CMD_SET_CUR, cpu, c, w, kind, rs, p, sl);
        else if (r < 80)
            send(CMD_SWITCH, cpu, c, w, kind, rs, p, sl);
        else
            send(CMD_KILL, cpu, c, w, kind, rs, live_pid(), sl);
    endtask

    initial begin
        sb = new();
        sent = 0;
        n_switch = 0;
        idle_pct = 31;
        i_rst_n = 0;
        i_valid = 0;
        i_command = CMD_CREATE;
        i_cpu = '0;
        i_context_word = '0;
        i_wake_time = '0;
        i_switch_kind = '0;
        i_resched_flag = 0;
        i_target_pid = '0;
        i_target_slot = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed corners
        send(CMD_KILL, 0, 0, 0, 0, 0, 16'h0000, 0);
        send(CMD_SWITCH, 0, 32'h1234, 0, 0, 1, 0, 0);
        send(CMD_CREATE, 0, 32'h0000_0000, 0, 0, 0, 0, 0);
        send(CMD_CREATE, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        send(CMD_CREATE, 0, 32'h0000_0001, 0, 0, 0, 0, 0);
        send(CMD_CREATE, 0, 32'h8000_0000, 0, 0, 0, 0, 0);
        send(CMD_SET_CUR, 0, 0, 0, 0, 0, 0, 4'd0);
        send(CMD_SET_CUR, 3, 0, 0, 0, 0, 0, 4'd1);
        send(CMD_SET_CUR, 2, 0, 0, 0, 0, 0, 4'd15);
        send(CMD_SWITCH, 0, 32'hA5A5_A5A5, 32'h55, KIND_TICK, 0, 0, 0);
        send(CMD_SWITCH, 0, 32'hFFFF_FFFF, 32'h55, KIND_TICK, 1, 0, 0);
        send(CMD_SWITCH, 0, 32'h0000_0000, 32'hFFFF_FFFF, KIND_BLOCK, 0, 0, 0);
        send(CMD_SWITCH, 0, 32'h1111_1111, 32'h0, 2'd0, 0, 0, 0);
        send(CMD_SWITCH, 3, 32'h2222_2222, 32'h0, 2'd3, 1, 0, 0);
        send(CMD_SWITCH, 1, 32'h3333_3333, 32'h0, 2'd0, 0, 0, 0);
        send(CMD_KILL, 0, 0, 0, 0, 0, sb.pid[sb.cur[0]], 0);
        send(CMD_KILL, 0, 0, 0, 0, 0, 16'hFFFF, 0);
        send(CMD_KILL, 0, 0, 0, 0, 0, 16'd3, 0);
        send(CMD_SET_CUR, 1, 0, 0, 0, 0, 0, 4'd2);

        // hold off until the block drains
        drain();

        for (int i = 0; i < NT + 1; i++)
            send(CMD_CREATE, 0, $urandom, 0, 0, 0, 0, 0);

        for (int i = 0; i < 515; i++) begin
            idle_pct = (i >= 200 && i < 300) ? 0 : 31;
            rand_item();
        end
        idle_pct = 31;

        i_valid = 0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (2 * NT + 20) @(posedge i_clk);
        $display("tb: %0d commands sent, %0d results checked, %0d switches", sent,
                 sb.checked, n_switch);
        $display("tb: covered empty/full table, tick/yield/block, live/running/missing kills");
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
